// File: rtl/csl_pkg.sv
// csl_pkg: shared types, token codes, keyword tables and character classes
// for the C-subset lexer. No dependencies; compiled first.
package csl_pkg;

  localparam int MAX_SOURCE_BYTES = 65536;
  localparam logic [15:0] OFFSET_CAP =
    16'(((MAX_SOURCE_BYTES - 1) < 65535) ? (MAX_SOURCE_BYTES - 1) : 65535);
  localparam logic [15:0] POS_MAX = 16'hFFFF;

  // result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int NUM_KW = 5;

  // token kinds
  localparam logic [4:0] K_LIT    = 5'd0;
  localparam logic [4:0] K_IDENT  = 5'd1;
  localparam logic [4:0] K_INT    = 5'd2;
  localparam logic [4:0] K_PLUS   = 5'd7;
  localparam logic [4:0] K_MINUS  = 5'd8;
  localparam logic [4:0] K_STAR   = 5'd9;
  localparam logic [4:0] K_DIV    = 5'd10;
  localparam logic [4:0] K_MOD    = 5'd11;
  localparam logic [4:0] K_EQEQ   = 5'd12;
  localparam logic [4:0] K_NE     = 5'd13;
  localparam logic [4:0] K_LT     = 5'd14;
  localparam logic [4:0] K_GT     = 5'd15;
  localparam logic [4:0] K_LE     = 5'd16;
  localparam logic [4:0] K_GE     = 5'd17;
  localparam logic [4:0] K_ASSIGN = 5'd18;
  localparam logic [4:0] K_LPAREN = 5'd19;
  localparam logic [4:0] K_RPAREN = 5'd20;
  localparam logic [4:0] K_LBRACE = 5'd21;
  localparam logic [4:0] K_RBRACE = 5'd22;
  localparam logic [4:0] K_SEMI   = 5'd23;
  localparam logic [4:0] K_EOF    = 5'd24;

  // characters
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BANG  = 8'h21;

  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_NUM     = 4'd1,
    M_IDENT   = 4'd2,
    M_SLASH   = 4'd3,
    M_COMMENT = 4'd4,
    M_EQ      = 4'd5,
    M_LT      = 4'd6,
    M_GT      = 4'd7,
    M_BANG    = 4'd8,
    M_ERR     = 4'd9
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [4:0]  kw;
    logic [15:0] offset;
    logic [15:0] line;
    logic [15:0] column;
    logic [15:0] ts_offset;
    logic [15:0] ts_line;
    logic [15:0] ts_column;
    logic [15:0] tlen;
  } lex_state_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic        is_error;
    logic [7:0]  error_char;
    logic [15:0] start_offset;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [15:0] lexeme_length;
    logic        last_of_source;
  } res_t;

  // keyword spelling: int, if, else, for, return
  function automatic logic [7:0] kw_char(input logic [2:0] b, input logic [2:0] idx);
    logic [47:0] s;
    begin
      case (b)
        3'd0:    s = {"int", 24'h0};
        3'd1:    s = {"if", 32'h0};
        3'd2:    s = {"else", 16'h0};
        3'd3:    s = {"for", 24'h0};
        3'd4:    s = "return";
        default: s = '0;
      endcase
      case (idx)
        3'd0:    kw_char = s[47:40];
        3'd1:    kw_char = s[39:32];
        3'd2:    kw_char = s[31:24];
        3'd3:    kw_char = s[23:16];
        3'd4:    kw_char = s[15:8];
        3'd5:    kw_char = s[7:0];
        default: kw_char = 8'h00;
      endcase
    end
  endfunction

  function automatic logic [2:0] kw_len(input logic [2:0] b);
    case (b)
      3'd0:    kw_len = 3'd3;
      3'd1:    kw_len = 3'd2;
      3'd2:    kw_len = 3'd4;
      3'd3:    kw_len = 3'd3;
      3'd4:    kw_len = 3'd6;
      default: kw_len = 3'd0;
    endcase
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == CH_UNDER;
  endfunction

  // kind of a one-character token, K_LIT when the byte is none
  function automatic logic [4:0] single_kind(input logic [7:0] c);
    case (c)
      8'h2B:   single_kind = K_PLUS;
      8'h2D:   single_kind = K_MINUS;
      8'h2A:   single_kind = K_STAR;
      8'h25:   single_kind = K_MOD;
      8'h28:   single_kind = K_LPAREN;
      8'h29:   single_kind = K_RPAREN;
      8'h7B:   single_kind = K_LBRACE;
      8'h7D:   single_kind = K_RBRACE;
      8'h3B:   single_kind = K_SEMI;
      default: single_kind = K_LIT;
    endcase
  endfunction

endpackage

// File: rtl/csl_if.sv
// csl_if: valid/ready channels for source words and token words.
// Depends on nothing; compiled after csl_pkg.
interface csl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_source;

  modport source(output valid, output char_code, output end_of_source, input ready);
  modport sink(input valid, input char_code, input end_of_source, output ready);
endinterface

interface csl_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic        is_error;
  logic [7:0]  error_char;
  logic [15:0] start_offset;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [15:0] lexeme_length;
  logic        last_of_source;

  modport source(output valid, output token_kind, output is_error, output error_char,
                 output start_offset, output start_line, output start_column,
                 output lexeme_length, output last_of_source, input ready);
  modport sink(input valid, input token_kind, input is_error, input error_char,
               input start_offset, input start_line, input start_column,
               input lexeme_length, input last_of_source, output ready);
endinterface

// File: rtl/c_subset_lexer_core.sv
// c_subset_lexer_core: streaming tokenizer, one source word per cycle while src is ready.
// A token word is written to the result queue as the source word that ends it is accepted.
// Throughput: one source word per cycle; a word can yield two token words, which drain
//   one per cycle while tok is ready via a 4-entry result queue; src stalls below two free slots.
// Reset: synchronous rst returns the scanner to idle at offset 0, line 1, column 1, and
//   empties the result queue. An end-of-source word rearms the scanner the same way.
// Depends on csl_pkg and csl_if.
module c_subset_lexer_core (
  input  logic             clk,
  input  logic             rst,
  csl_in_if.sink           src,
  csl_out_if.source        tok
);

  // scanner state: mode, keyword candidates, position and pending token start
  csl_pkg::lex_state_t st;
  csl_pkg::lex_state_t st_next;

  // result queue
  csl_pkg::res_t               q [csl_pkg::QDEPTH];
  logic [csl_pkg::QPTR_W-1:0]  head;
  logic [csl_pkg::QPTR_W-1:0]  tail;
  logic [csl_pkg::QCNT_W-1:0]  count;

  logic          accept;
  logic          pop;
  logic          a_v, b_v;        // first result (pending token), second (this byte / eof)
  csl_pkg::res_t a_r, b_r;
  logic [1:0]    push_n;
  csl_pkg::res_t r0, r1;
  logic [7:0]    c;

  // ---------------------------------------------------------------------------
  // Step helpers
  // ---------------------------------------------------------------------------

  // Advance offset/line/column past one byte, all saturating.
  function automatic csl_pkg::lex_state_t step_pos(input csl_pkg::lex_state_t s,
                                                   input logic [7:0] ch);
    csl_pkg::lex_state_t r;
    begin
      r = s;
      if (r.offset < csl_pkg::OFFSET_CAP) r.offset = r.offset + 16'd1;
      if (ch == csl_pkg::CH_LF) begin
        if (r.line < csl_pkg::POS_MAX) r.line = r.line + 16'd1;
        r.column = 16'd1;
      end else if (r.column < csl_pkg::POS_MAX) begin
        r.column = r.column + 16'd1;
      end
      return r;
    end
  endfunction

  // Latch the token start at the current position.
  function automatic csl_pkg::lex_state_t begin_tok(input csl_pkg::lex_state_t s,
                                                    input csl_pkg::mode_t m);
    csl_pkg::lex_state_t r;
    begin
      r = s;
      r.ts_offset = s.offset;
      r.ts_line   = s.line;
      r.ts_column = s.column;
      r.tlen      = 16'd1;
      r.mode      = m;
      return r;
    end
  endfunction

  function automatic csl_pkg::lex_state_t grow(input csl_pkg::lex_state_t s,
                                               input logic [7:0] ch);
    csl_pkg::lex_state_t r;
    begin
      r = s;
      if (r.tlen < csl_pkg::POS_MAX) r.tlen = r.tlen + 16'd1;
      return step_pos(r, ch);
    end
  endfunction

  // Drop keyword candidates that do not have byte ch at position idx.
  function automatic logic [4:0] filter_kw(input logic [4:0] kw, input logic [7:0] ch,
                                           input logic [15:0] idx);
    logic [4:0] r;
    begin
      r = kw;
      for (int b = 0; b < csl_pkg::NUM_KW; b++) begin
        if (idx >= {13'd0, csl_pkg::kw_len(3'(b))} ||
            csl_pkg::kw_char(3'(b), idx[2:0]) != ch)
          r[b] = 1'b0;
      end
      return r;
    end
  endfunction

  // Lowest surviving keyword whose length matches wins; else identifier.
  function automatic logic [4:0] ident_kind(input logic [4:0] kw, input logic [15:0] len);
    logic [4:0] k;
    begin
      k = csl_pkg::K_IDENT;
      for (int b = csl_pkg::NUM_KW - 1; b >= 0; b--) begin
        if (kw[b] && len == {13'd0, csl_pkg::kw_len(3'(b))})
          k = csl_pkg::K_INT + 5'(b);
      end
      return k;
    end
  endfunction

  function automatic csl_pkg::res_t mk_res(input logic [4:0] kind, input logic err,
                                           input logic [7:0] ch, input logic [15:0] off,
                                           input logic [15:0] ln, input logic [15:0] col,
                                           input logic [15:0] len, input logic last);
    csl_pkg::res_t r;
    begin
      r.token_kind     = kind;
      r.is_error       = err;
      r.error_char     = ch;
      r.start_offset   = off;
      r.start_line     = ln;
      r.start_column   = col;
      r.lexeme_length  = len;
      r.last_of_source = last;
      return r;
    end
  endfunction

  function automatic csl_pkg::res_t pend(input csl_pkg::lex_state_t s, input logic [4:0] kind);
    return mk_res(kind, 1'b0, 8'h00, s.ts_offset, s.ts_line, s.ts_column, s.tlen, 1'b0);
  endfunction

  function automatic csl_pkg::lex_state_t rearm();
    csl_pkg::lex_state_t r;
    begin
      r.mode      = csl_pkg::M_IDLE;
      r.kw        = 5'h1F;
      r.offset    = 16'd0;
      r.line      = 16'd1;
      r.column    = 16'd1;
      r.ts_offset = 16'd0;
      r.ts_line   = 16'd1;
      r.ts_column = 16'd1;
      r.tlen      = 16'd0;
      return r;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Handshakes: take a source word only while two queue slots are free
  // ---------------------------------------------------------------------------
  assign src.ready = (count <= csl_pkg::QCNT_W'(csl_pkg::QDEPTH - 2));
  assign accept    = src.valid && src.ready;
  assign pop       = tok.valid && tok.ready;
  assign c         = src.char_code;

  // ---------------------------------------------------------------------------
  // Scanner step: one source word -> next state plus up to two results
  // ---------------------------------------------------------------------------
  always_comb begin
    logic go_idle;
    logic [4:0] sk;
    st_next = st;
    a_v     = 1'b0;
    b_v     = 1'b0;
    a_r     = '0;
    b_r     = '0;
    go_idle = 1'b0;
    sk      = csl_pkg::single_kind(c);

    if (accept) begin
      if (src.end_of_source) begin
        // flush the pending token, then eof; a lone bang reports instead of eof, and after an error no eof
        case (st.mode)
          csl_pkg::M_NUM:   begin a_v = 1'b1; a_r = pend(st, csl_pkg::K_LIT); end
          csl_pkg::M_IDENT: begin a_v = 1'b1; a_r = pend(st, ident_kind(st.kw, st.tlen)); end
          csl_pkg::M_SLASH: begin a_v = 1'b1; a_r = pend(st, csl_pkg::K_DIV); end
          csl_pkg::M_EQ:    begin a_v = 1'b1; a_r = pend(st, csl_pkg::K_ASSIGN); end
          csl_pkg::M_LT:    begin a_v = 1'b1; a_r = pend(st, csl_pkg::K_LT); end
          csl_pkg::M_GT:    begin a_v = 1'b1; a_r = pend(st, csl_pkg::K_GT); end
          csl_pkg::M_BANG: begin
            a_v = 1'b1;
            a_r = mk_res(csl_pkg::K_LIT, 1'b1, csl_pkg::CH_BANG, st.ts_offset, st.ts_line,
                         st.ts_column, 16'd1, 1'b1);
          end
          default: ;
        endcase
        if (st.mode != csl_pkg::M_BANG && st.mode != csl_pkg::M_ERR) begin
          b_v = 1'b1;
          b_r = mk_res(csl_pkg::K_EOF, 1'b0, 8'h00, st.offset, st.line, st.column,
                       16'd0, 1'b1);
        end
        st_next = rearm();
      end else begin
        case (st.mode)
          csl_pkg::M_ERR: ;  // drop bytes until end of source
          csl_pkg::M_NUM: begin
            if (csl_pkg::is_digit(c)) begin
              st_next = grow(st, c);
            end else begin
              a_v = 1'b1; a_r = pend(st, csl_pkg::K_LIT); go_idle = 1'b1;
            end
          end
          csl_pkg::M_IDENT: begin
            if (csl_pkg::is_word(c)) begin
              st_next    = grow(st, c);
              st_next.kw = filter_kw(st.kw, c, st.tlen);
            end else begin
              a_v = 1'b1; a_r = pend(st, ident_kind(st.kw, st.tlen)); go_idle = 1'b1;
            end
          end
          csl_pkg::M_SLASH: begin
            if (c == csl_pkg::CH_SLASH) begin
              st_next      = step_pos(st, c);
              st_next.mode = csl_pkg::M_COMMENT;
            end else begin
              a_v = 1'b1; a_r = pend(st, csl_pkg::K_DIV); go_idle = 1'b1;
            end
          end
          csl_pkg::M_COMMENT: begin
            st_next = step_pos(st, c);
            if (c == csl_pkg::CH_LF) st_next.mode = csl_pkg::M_IDLE;
          end
          csl_pkg::M_EQ, csl_pkg::M_LT, csl_pkg::M_GT, csl_pkg::M_BANG: begin
            if (c == csl_pkg::CH_EQ) begin
              // two-character compare closes here, including this byte
              st_next = grow(st, c);
              a_v     = 1'b1;
              case (st.mode)
                csl_pkg::M_EQ: a_r = pend(st_next, csl_pkg::K_EQEQ);
                csl_pkg::M_LT: a_r = pend(st_next, csl_pkg::K_LE);
                csl_pkg::M_GT: a_r = pend(st_next, csl_pkg::K_GE);
                default:       a_r = pend(st_next, csl_pkg::K_NE);
              endcase
              st_next.mode = csl_pkg::M_IDLE;
            end else if (st.mode == csl_pkg::M_BANG) begin
              // lone bang: error at the bang, drop this byte
              a_v = 1'b1;
              a_r = mk_res(csl_pkg::K_LIT, 1'b1, csl_pkg::CH_BANG, st.ts_offset, st.ts_line,
                           st.ts_column, 16'd1, 1'b1);
              st_next.mode = csl_pkg::M_ERR;
            end else begin
              a_v = 1'b1;
              case (st.mode)
                csl_pkg::M_EQ: a_r = pend(st, csl_pkg::K_ASSIGN);
                csl_pkg::M_LT: a_r = pend(st, csl_pkg::K_LT);
                default:       a_r = pend(st, csl_pkg::K_GT);
              endcase
              go_idle = 1'b1;
            end
          end
          default: go_idle = 1'b1;
        endcase

        // byte seen from idle: skip a blank, start a token, emit a one-char token, or fail
        if (go_idle) begin
          st_next.mode = csl_pkg::M_IDLE;
          if (csl_pkg::is_space(c)) begin
            st_next = step_pos(st_next, c);
          end else if (csl_pkg::is_digit(c)) begin
            st_next = step_pos(begin_tok(st_next, csl_pkg::M_NUM), c);
          end else if (csl_pkg::is_alpha(c) || c == csl_pkg::CH_UNDER) begin
            st_next    = step_pos(begin_tok(st_next, csl_pkg::M_IDENT), c);
            st_next.kw = filter_kw(5'h1F, c, 16'd0);
          end else if (sk != csl_pkg::K_LIT) begin
            b_v = 1'b1;
            b_r = mk_res(sk, 1'b0, 8'h00, st_next.offset, st_next.line, st_next.column,
                         16'd1, 1'b0);
            st_next = step_pos(st_next, c);
          end else if (c == csl_pkg::CH_SLASH) begin
            st_next = step_pos(begin_tok(st_next, csl_pkg::M_SLASH), c);
          end else if (c == csl_pkg::CH_EQ) begin
            st_next = step_pos(begin_tok(st_next, csl_pkg::M_EQ), c);
          end else if (c == csl_pkg::CH_LT) begin
            st_next = step_pos(begin_tok(st_next, csl_pkg::M_LT), c);
          end else if (c == csl_pkg::CH_GT) begin
            st_next = step_pos(begin_tok(st_next, csl_pkg::M_GT), c);
          end else if (c == csl_pkg::CH_BANG) begin
            st_next = step_pos(begin_tok(st_next, csl_pkg::M_BANG), c);
          end else begin
            b_v = 1'b1;
            b_r = mk_res(csl_pkg::K_LIT, 1'b1, c, st_next.offset, st_next.line,
                         st_next.column, 16'd1, 1'b1);
            st_next.mode = csl_pkg::M_ERR;
          end
        end
      end
    end
  end

  // compact the two result slots
  assign push_n = 2'(a_v) + 2'(b_v);
  assign r0     = a_v ? a_r : b_r;
  assign r1     = b_r;

  // ---------------------------------------------------------------------------
  // State and queue registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= rearm();
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      st    <= st_next;
      head  <= head + csl_pkg::QPTR_W'(pop);
      tail  <= tail + csl_pkg::QPTR_W'(push_n);
      count <= count + csl_pkg::QCNT_W'(push_n) - csl_pkg::QCNT_W'(pop);
    end
  end

  // queue payload: write one or two results at the tail
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q[tail] <= r0;
    if (push_n == 2'd2) q[tail + csl_pkg::QPTR_W'(1)] <= r1;
  end

  // ---------------------------------------------------------------------------
  // Token word output from the queue head
  // ---------------------------------------------------------------------------
  assign tok.valid          = (count != '0);
  assign tok.token_kind     = q[head].token_kind;
  assign tok.is_error       = q[head].is_error;
  assign tok.error_char     = q[head].error_char;
  assign tok.start_offset   = q[head].start_offset;
  assign tok.start_line     = q[head].start_line;
  assign tok.start_column   = q[head].start_column;
  assign tok.lexeme_length  = q[head].lexeme_length;
  assign tok.last_of_source = q[head].last_of_source;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= csl_pkg::QCNT_W'(csl_pkg::QDEPTH))
    else $error("result queue overfilled");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (tail - head) == count[csl_pkg::QPTR_W-1:0])
    else $error("queue pointers disagree with count");

  a_eos_rearm: assert property (@(posedge clk) disable iff (rst)
    accept && src.end_of_source |=> st.mode == csl_pkg::M_IDLE && st.offset == 16'd0 &&
                                    st.line == 16'd1 && st.column == 16'd1)
    else $error("end of source did not rearm the scanner");

  a_err_silent: assert property (@(posedge clk) disable iff (rst)
    accept && !src.end_of_source && st.mode == csl_pkg::M_ERR |-> push_n == 2'd0)
    else $error("result produced after an error");

  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    push_n != 2'd0 && r0.is_error |-> r0.token_kind == csl_pkg::K_LIT && r0.last_of_source)
    else $error("error result malformed");

endmodule

// File: tb/sv/tb_c_subset_lexer_core.sv
`timescale 1ns / 100ps
// tb_c_subset_lexer_core: self-checking bench for the C-subset lexer core.
// Streams source words through csl_in_if, checks token words on csl_out_if
// against a cycle-free model of the tokenizer. Needs csl_pkg, csl_if and the core.
module tb_c_subset_lexer_core;

  // Source words the driver still has to offer.
  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
  } src_word_t;

  localparam int IDLE_PCT      = 14;
  localparam int RANDOM_WORDS  = 1450;
  // Sink hold-off and calm windows in cycles, and the driver's steady window in sent words.
  localparam int HOLD_FROM     = 200;
  localparam int HOLD_LEN      = 90;
  localparam int CALM_FROM     = 1200;
  localparam int CALM_TO       = 1700;
  localparam int STEADY_FROM   = 700;
  localparam int STEADY_TO     = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 4000;

  logic clk;
  logic rst;

  csl_in_if  src_if ();
  csl_out_if tok_if ();

  c_subset_lexer_core u_top (
    .clk (clk),
    .rst (rst),
    .src (src_if),
    .tok (tok_if)
  );

  always #10 clk = ~clk;

  src_word_t     src_q[$];
  csl_pkg::res_t token_expect[$];

  int words_sent   = 0;
  int gen_words    = 0;
  int sink_cycles  = 0;
  int quiet_cycles = 0;
  int tokens_seen  = 0;
  int mismatches   = 0;

  string kw_spell[5] = '{"int", "if", "else", "for", "return"};
  string id_first    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string id_rest     = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string one_ops     = "+-*%(){};";
  string lead_ops    = "=<>/";
  string pair_ops[4] = '{"==", "!=", "<=", ">="};

  // ---------------------------------------------------------------------------
  // Tokenizer model: its own copy of the scanner state.
  // ---------------------------------------------------------------------------
  csl_pkg::mode_t lx_mode;
  logic [4:0]     lx_kw;
  logic [15:0]    lx_off, lx_line, lx_col;
  logic [15:0]    lx_ts_off, lx_ts_line, lx_ts_col, lx_tlen;

  function automatic logic digit_byte(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic letter_byte(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic word_byte(logic [7:0] c);
    return letter_byte(c) || digit_byte(c) || c == csl_pkg::CH_UNDER;
  endfunction

  function automatic logic blank_byte(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // Kind of a token that is complete in one byte; K_LIT when none.
  function automatic logic [4:0] punct_kind(logic [7:0] c);
    case (c)
      "+":     return csl_pkg::K_PLUS;
      "-":     return csl_pkg::K_MINUS;
      "*":     return csl_pkg::K_STAR;
      "%":     return csl_pkg::K_MOD;
      "(":     return csl_pkg::K_LPAREN;
      ")":     return csl_pkg::K_RPAREN;
      "{":     return csl_pkg::K_LBRACE;
      "}":     return csl_pkg::K_RBRACE;
      ";":     return csl_pkg::K_SEMI;
      default: return csl_pkg::K_LIT;
    endcase
  endfunction

  // A byte that no token may start with.
  function automatic logic stray_byte(logic [7:0] c);
    return !(blank_byte(c) || word_byte(c) || punct_kind(c) != csl_pkg::K_LIT ||
             c == csl_pkg::CH_SLASH || c == csl_pkg::CH_EQ || c == csl_pkg::CH_LT ||
             c == csl_pkg::CH_GT || c == csl_pkg::CH_BANG);
  endfunction

  function automatic void rearm();
    lx_mode    = csl_pkg::M_IDLE;
    lx_kw      = 5'h1F;
    lx_off     = '0;
    lx_line    = 16'd1;
    lx_col     = 16'd1;
    lx_ts_off  = '0;
    lx_ts_line = 16'd1;
    lx_ts_col  = 16'd1;
    lx_tlen    = '0;
  endfunction

  function automatic void note(logic [4:0] kind, logic err, logic [7:0] ch,
                               logic [15:0] off, logic [15:0] line, logic [15:0] col,
                               logic [15:0] len, logic last);
    csl_pkg::res_t r;
    r.token_kind     = kind;
    r.is_error       = err;
    r.error_char     = ch;
    r.start_offset   = off;
    r.start_line     = line;
    r.start_column   = col;
    r.lexeme_length  = len;
    r.last_of_source = last;
    token_expect = {token_expect, r};
  endfunction

  function automatic void emit_pending(logic [4:0] kind);
    note(kind, 1'b0, 8'h00, lx_ts_off, lx_ts_line, lx_ts_col, lx_tlen, 1'b0);
  endfunction

  // Move the position past one byte; all counters saturate.
  function automatic void advance(logic [7:0] c);
    if (lx_off < csl_pkg::OFFSET_CAP) lx_off++;
    if (c == csl_pkg::CH_LF) begin
      if (lx_line < csl_pkg::POS_MAX) lx_line++;
      lx_col = 16'd1;
    end else if (lx_col < csl_pkg::POS_MAX) begin
      lx_col++;
    end
  endfunction

  function automatic void open_token(csl_pkg::mode_t m);
    lx_ts_off  = lx_off;
    lx_ts_line = lx_line;
    lx_ts_col  = lx_col;
    lx_tlen    = 16'd1;
    lx_mode    = m;
  endfunction

  function automatic void extend(logic [7:0] c);
    if (lx_tlen < csl_pkg::POS_MAX) lx_tlen++;
    advance(c);
  endfunction

  // Drop every keyword that does not have byte c at position idx.
  function automatic void prune_kw(logic [7:0] c, int idx);
    for (int b = 0; b < 5; b++)
      if (idx >= kw_spell[b].len() || kw_spell[b][idx] != c) lx_kw[b] = 1'b0;
  endfunction

  function automatic logic [4:0] word_kind();
    for (int b = 0; b < 5; b++)
      if (lx_kw[b] && kw_spell[b].len() == int'(lx_tlen)) return csl_pkg::K_INT + 5'(b);
    return csl_pkg::K_IDENT;
  endfunction

  function automatic void idle_start(logic [7:0] c);
    logic [4:0] k;
    k = punct_kind(c);
    if (blank_byte(c)) begin
      advance(c);
    end else if (digit_byte(c)) begin
      open_token(csl_pkg::M_NUM);
      advance(c);
    end else if (letter_byte(c) || c == csl_pkg::CH_UNDER) begin
      open_token(csl_pkg::M_IDENT);
      lx_kw = 5'h1F;
      prune_kw(c, 0);
      advance(c);
    end else if (k != csl_pkg::K_LIT) begin
      note(k, 1'b0, 8'h00, lx_off, lx_line, lx_col, 16'd1, 1'b0);
      advance(c);
    end else if (c == csl_pkg::CH_SLASH) begin
      open_token(csl_pkg::M_SLASH);
      advance(c);
    end else if (c == csl_pkg::CH_EQ) begin
      open_token(csl_pkg::M_EQ);
      advance(c);
    end else if (c == csl_pkg::CH_LT) begin
      open_token(csl_pkg::M_LT);
      advance(c);
    end else if (c == csl_pkg::CH_GT) begin
      open_token(csl_pkg::M_GT);
      advance(c);
    end else if (c == csl_pkg::CH_BANG) begin
      open_token(csl_pkg::M_BANG);
      advance(c);
    end else begin
      note(csl_pkg::K_LIT, 1'b1, c, lx_off, lx_line, lx_col, 16'd1, 1'b1);
      lx_mode = csl_pkg::M_ERR;
    end
  endfunction

  // Take one accepted source word and queue the token words it must produce.
  function automatic void absorb(logic [7:0] c, logic eos);
    logic [4:0] k;
    if (eos) begin
      case (lx_mode)
        csl_pkg::M_NUM:   emit_pending(csl_pkg::K_LIT);
        csl_pkg::M_IDENT: emit_pending(word_kind());
        csl_pkg::M_SLASH: emit_pending(csl_pkg::K_DIV);
        csl_pkg::M_EQ:    emit_pending(csl_pkg::K_ASSIGN);
        csl_pkg::M_LT:    emit_pending(csl_pkg::K_LT);
        csl_pkg::M_GT:    emit_pending(csl_pkg::K_GT);
        default: ;
      endcase
      // A dangling bang reports instead of eof; after an error nothing follows.
      if (lx_mode == csl_pkg::M_BANG)
        note(csl_pkg::K_LIT, 1'b1, csl_pkg::CH_BANG, lx_ts_off, lx_ts_line, lx_ts_col,
             16'd1, 1'b1);
      else if (lx_mode != csl_pkg::M_ERR)
        note(csl_pkg::K_EOF, 1'b0, 8'h00, lx_off, lx_line, lx_col, 16'd0, 1'b1);
      rearm();
      return;
    end
    case (lx_mode)
      csl_pkg::M_ERR: return;
      csl_pkg::M_NUM: begin
        if (digit_byte(c)) begin
          extend(c);
          return;
        end
        emit_pending(csl_pkg::K_LIT);
      end
      csl_pkg::M_IDENT: begin
        if (word_byte(c)) begin
          prune_kw(c, int'(lx_tlen));
          extend(c);
          return;
        end
        emit_pending(word_kind());
      end
      csl_pkg::M_SLASH: begin
        if (c == csl_pkg::CH_SLASH) begin
          lx_mode = csl_pkg::M_COMMENT;
          advance(c);
          return;
        end
        emit_pending(csl_pkg::K_DIV);
      end
      csl_pkg::M_COMMENT: begin
        advance(c);
        if (c == csl_pkg::CH_LF) lx_mode = csl_pkg::M_IDLE;
        return;
      end
      csl_pkg::M_EQ, csl_pkg::M_LT, csl_pkg::M_GT, csl_pkg::M_BANG: begin
        if (c == csl_pkg::CH_EQ) begin
          case (lx_mode)
            csl_pkg::M_EQ: k = csl_pkg::K_EQEQ;
            csl_pkg::M_LT: k = csl_pkg::K_LE;
            csl_pkg::M_GT: k = csl_pkg::K_GE;
            default:       k = csl_pkg::K_NE;
          endcase
          extend(c);
          emit_pending(k);
          lx_mode = csl_pkg::M_IDLE;
          return;
        end
        if (lx_mode == csl_pkg::M_BANG) begin
          note(csl_pkg::K_LIT, 1'b1, csl_pkg::CH_BANG, lx_ts_off, lx_ts_line, lx_ts_col,
               16'd1, 1'b1);
          lx_mode = csl_pkg::M_ERR;
          return;
        end
        emit_pending(lx_mode == csl_pkg::M_EQ ? csl_pkg::K_ASSIGN :
                     lx_mode == csl_pkg::M_LT ? csl_pkg::K_LT : csl_pkg::K_GT);
      end
      default: ;
    endcase
    lx_mode = csl_pkg::M_IDLE;
    idle_start(c);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders: fill src_q, counting words that the lexer acts on.
  // ---------------------------------------------------------------------------
  task automatic push_word(logic [7:0] ch, logic eos, bit counted);
    src_word_t w;
    w.ch  = ch;
    w.eos = eos;
    src_q = {src_q, w};
    if (counted) gen_words++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_word(s[i], 1'b0, 1'b1);
  endtask

  task automatic push_eos();
    push_word(8'h00, 1'b1, 1'b1);
  endtask

  function automatic logic [7:0] pick_stray();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (!stray_byte(b));
    return b;
  endfunction

  // Append one random token, well formed but with random spelling.
  task automatic add_token();
    int    n;
    int    b;
    string s;
    case ($urandom_range(0, 11))
      0, 1: begin
        n = $urandom_range(1, 5);
        repeat (n) push_word(8'h30 + 8'($urandom_range(0, 9)), 1'b0, 1'b1);
      end
      2, 3, 4: begin
        push_word(id_first[$urandom_range(0, id_first.len() - 1)], 1'b0, 1'b1);
        n = $urandom_range(0, 6);
        repeat (n) push_word(id_rest[$urandom_range(0, id_rest.len() - 1)], 1'b0, 1'b1);
      end
      5, 6, 11: begin
        // keyword, a prefix of one, or one with an extra word byte
        s = kw_spell[$urandom_range(0, 4)];
        n = $urandom_range(0, 9);
        if (n >= 6 && n < 8) s = s.substr(0, $urandom_range(0, s.len() - 2));
        push_text(s);
        if (n >= 8) push_word(id_rest[$urandom_range(0, id_rest.len() - 1)], 1'b0, 1'b1);
      end
      7: push_word(one_ops[$urandom_range(0, one_ops.len() - 1)], 1'b0, 1'b1);
      8: push_text(pair_ops[$urandom_range(0, 3)]);
      9: push_word(lead_ops[$urandom_range(0, lead_ops.len() - 1)], 1'b0, 1'b1);
      default: begin
        // line comment with any bytes but LF in its body
        push_text("//");
        n = $urandom_range(0, 8);
        repeat (n) begin
          b = $urandom_range(0, 254);
          if (b >= 10) b++;
          push_word(8'(b), 1'b0, 1'b1);
        end
        push_word(csl_pkg::CH_LF, 1'b0, 1'b1);
      end
    endcase
  endtask

  task automatic add_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r >= 8) push_word(r == 9 ? 8'(" ") : 8'($urandom_range(9, 13)), 1'b0, 1'b1);
    else if (r >= 4) push_word(" ", 1'b0, 1'b1);
  endtask

  // One source: mostly token streams, some raw noise, some that break midway.
  task automatic add_source();
    int   r;
    int   n;
    bit   live;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    n = $urandom_range(1, 16);
    if (r < 4) begin
      push_eos();
      return;
    end
    if (r < 82) begin
      repeat (n) begin
        add_token();
        add_gap();
      end
    end else if (r < 90) begin
      live = 1'b1;
      repeat (n) begin
        b = 8'($urandom_range(0, 255));
        push_word(b, 1'b0, live);
        if (stray_byte(b)) live = 1'b0;
      end
    end else begin
      repeat (n / 2) begin
        add_token();
        add_gap();
      end
      case ($urandom_range(0, 2))
        0: push_word(pick_stray(), 1'b0, 1'b1);
        1: begin
          push_word(csl_pkg::CH_BANG, 1'b0, 1'b1);
          push_word(id_rest[$urandom_range(0, id_rest.len() - 1)], 1'b0, 1'b1);
        end
        default: begin
          // lone bang right before end of source
          push_word(csl_pkg::CH_BANG, 1'b0, 1'b1);
          push_eos();
          return;
        end
      endcase
      n = $urandom_range(0, 4);
      repeat (n) push_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    end
    push_eos();
  endtask

  // Hold the sender until every word is in and every token word is out.
  task automatic settle();
    while (src_q.size() != 0 || src_if.valid === 1'b1 || token_expect.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic report_mismatch(string field, int got, int want);
    mismatches++;
    $display("mismatch: token word %0d %s got %0d expected %0d",
             tokens_seen, field, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Source driver: offer the next queued word when the channel is free.
  // Idle at random, except over a window of sent words where it never idles.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_src
    src_word_t w;
    bit        steady;
    steady = words_sent >= STEADY_FROM && words_sent < STEADY_TO;
    if (rst) begin
      src_if.valid <= 1'b0;
    end else if (!src_if.valid || src_if.ready) begin
      if (src_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        w = src_q.pop_front();
        src_if.valid         <= 1'b1;
        src_if.char_code     <= w.ch;
        src_if.end_of_source <= w.eos;
        words_sent           <= words_sent + 1;
      end else begin
        src_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Token sink: random back-pressure, one long hold-off that fills the core's
  // result queue and stalls its input, and a calm stretch with ready held high.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sink_cycles <= sink_cycles + 1;
    if (rst)
      tok_if.ready <= 1'b0;
    else if (sink_cycles >= HOLD_FROM && sink_cycles < HOLD_FROM + HOLD_LEN)
      tok_if.ready <= 1'b0;
    else if (sink_cycles >= CALM_FROM && sink_cycles < CALM_TO)
      tok_if.ready <= 1'b1;
    else
      tok_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // ---------------------------------------------------------------------------
  // Monitor: check the token word taken at this edge first, then feed the
  // model with the source word taken at this edge (its tokens come later).
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    csl_pkg::res_t want;
    if (!rst) begin
      if (tok_if.valid === 1'b1 && tok_if.ready === 1'b1) begin
        if (token_expect.size() == 0) begin
          report_mismatch("unexpected word, kind", int'(tok_if.token_kind), -1);
        end else begin
          want = token_expect.pop_front();
          if (tok_if.token_kind !== want.token_kind)
            report_mismatch("token_kind", int'(tok_if.token_kind),
                            int'(want.token_kind));
          if (tok_if.is_error !== want.is_error)
            report_mismatch("is_error", int'(tok_if.is_error), int'(want.is_error));
          if (tok_if.error_char !== want.error_char)
            report_mismatch("error_char", int'(tok_if.error_char),
                            int'(want.error_char));
          if (tok_if.start_offset !== want.start_offset)
            report_mismatch("start_offset", int'(tok_if.start_offset),
                            int'(want.start_offset));
          if (tok_if.start_line !== want.start_line)
            report_mismatch("start_line", int'(tok_if.start_line),
                            int'(want.start_line));
          if (tok_if.start_column !== want.start_column)
            report_mismatch("start_column", int'(tok_if.start_column),
                            int'(want.start_column));
          if (tok_if.lexeme_length !== want.lexeme_length)
            report_mismatch("lexeme_length", int'(tok_if.lexeme_length),
                            int'(want.lexeme_length));
          if (tok_if.last_of_source !== want.last_of_source)
            report_mismatch("last_of_source", int'(tok_if.last_of_source),
                            int'(want.last_of_source));
        end
        tokens_seen++;
      end
      if (src_if.valid === 1'b1 && src_if.ready === 1'b1)
        absorb(src_if.char_code, src_if.end_of_source);
    end
  end

  // Watchdog: give up when no word moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (src_if.valid === 1'b1 && src_if.ready === 1'b1) ||
        (tok_if.valid === 1'b1 && tok_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed sources, random sources.
  // ---------------------------------------------------------------------------
  initial begin
    clk                  = 1'b0;
    rst                  = 1'b1;
    src_if.valid         = 1'b0;
    src_if.char_code     = 8'h00;
    src_if.end_of_source = 1'b0;
    tok_if.ready         = 1'b0;
    rearm();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: compares, a comment left open at the end, a pending '>' at
    // the end, a bang eating the next byte, a bang right before the end,
    // a high unknown byte, an empty source and a lone slash.
    push_text("x!=1//");
    push_eos();
    push_text("a<=b>");
    push_eos();
    push_text("!y");
    push_eos();
    push_text("x!");
    push_eos();
    push_word(8'hFF, 1'b0, 1'b1);
    push_eos();
    push_eos();
    push_text("/");
    push_eos();
    settle();

    // Random sources; the sender then pauses until the last token word is out.
    @(negedge clk);
    gen_words = 0;
    while (gen_words < RANDOM_WORDS) add_source();
    settle();

    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: c_subset_lexer_core.f
rtl/csl_pkg.sv
rtl/csl_if.sv
rtl/c_subset_lexer_core.sv
tb/sv/tb_c_subset_lexer_core.sv
